[sv/tun_pkg.sv]
`timescale 1ns / 1ps
package tun_pkg;
   localparam int COORD_BITS    = 16;
   localparam int FRACTION_BITS = 15;
   localparam int OUT_BITS      = 16;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int PROD_BITS     = 2 * DIFF_BITS;
   localparam int NRM_BITS      = 2 * COORD_BITS + 2;
   localparam int MAG_BITS      = 2 * COORD_BITS + 1;
   localparam int LZ_BITS       = $clog2(MAG_BITS + 1);
   localparam int NORM_BITS     = 30;
   localparam int SQR_BITS      = 2 * NORM_BITS;
   localparam int ROOT_BITS     = NORM_BITS + 1;
   localparam int SUM_BITS      = 2 * ROOT_BITS;
   localparam int SQ_REM_BITS   = ROOT_BITS + 3;
   localparam int QUO_BITS      = FRACTION_BITS + 1;
   localparam int DIV_BITS      = NORM_BITS + FRACTION_BITS + 1;
   localparam int DREM_BITS     = ROOT_BITS + 1;
   localparam int LIMIT_INT     = ((1 << FRACTION_BITS) - 1 > 32767) ?
                                  32767 : (1 << FRACTION_BITS) - 1;
   localparam logic [QUO_BITS-1:0] LIMIT = QUO_BITS'(LIMIT_INT);
   localparam int QUEUE_DEPTH   = 8;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = QPTR_BITS + 1;
   localparam int FRONT_STAGES  = 3;
   localparam logic [QCNT_BITS-1:0] QUEUE_ROOM = QCNT_BITS'(QUEUE_DEPTH - FRONT_STAGES);

   typedef struct packed {
      logic signed [NRM_BITS-1:0] n_x;
      logic signed [NRM_BITS-1:0] n_y;
      logic signed [NRM_BITS-1:0] n_z;
   } normal_type;

   typedef struct packed {
      logic                 deg;
      logic [2:0]           neg;
      logic [NORM_BITS-1:0] m_x;
      logic [NORM_BITS-1:0] m_y;
      logic [NORM_BITS-1:0] m_z;
   } side_type;
endpackage

[sv/tun_front.sv]
`timescale 1ns / 1ps
module tun_front import tun_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic signed [COORD_BITS-1:0] a_x,
   input  logic signed [COORD_BITS-1:0] a_y,
   input  logic signed [COORD_BITS-1:0] a_z,
   input  logic signed [COORD_BITS-1:0] b_x,
   input  logic signed [COORD_BITS-1:0] b_y,
   input  logic signed [COORD_BITS-1:0] b_z,
   input  logic signed [COORD_BITS-1:0] c_x,
   input  logic signed [COORD_BITS-1:0] c_y,
   input  logic signed [COORD_BITS-1:0] c_z,
   output logic                         push,
   output normal_type                   push_data
);
   logic signed [DIFF_BITS-1:0] u_ff [3];
   logic signed [DIFF_BITS-1:0] v_ff [3];
   logic signed [DIFF_BITS-1:0] u_in [3];
   logic signed [DIFF_BITS-1:0] v_in [3];
   logic signed [PROD_BITS-1:0] p_ff [6];
   logic signed [PROD_BITS-1:0] p_in [6];
   logic signed [NRM_BITS:0]    n_in [3];
   logic                        d_valid_ff, p_valid_ff, n_valid_ff;
   normal_type                  n_ff;

   always_comb begin
      u_in[0] = DIFF_BITS'(b_x) - DIFF_BITS'(a_x);
      u_in[1] = DIFF_BITS'(b_y) - DIFF_BITS'(a_y);
      u_in[2] = DIFF_BITS'(b_z) - DIFF_BITS'(a_z);
      v_in[0] = DIFF_BITS'(c_x) - DIFF_BITS'(a_x);
      v_in[1] = DIFF_BITS'(c_y) - DIFF_BITS'(a_y);
      v_in[2] = DIFF_BITS'(c_z) - DIFF_BITS'(a_z);
      p_in[0] = u_ff[1] * v_ff[2];
      p_in[1] = u_ff[2] * v_ff[1];
      p_in[2] = u_ff[2] * v_ff[0];
      p_in[3] = u_ff[0] * v_ff[2];
      p_in[4] = u_ff[0] * v_ff[1];
      p_in[5] = u_ff[1] * v_ff[0];
      n_in[0] = (NRM_BITS+1)'(p_ff[0]) - (NRM_BITS+1)'(p_ff[1]);
      n_in[1] = (NRM_BITS+1)'(p_ff[2]) - (NRM_BITS+1)'(p_ff[3]);
      n_in[2] = (NRM_BITS+1)'(p_ff[4]) - (NRM_BITS+1)'(p_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         n_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= accept;
         p_valid_ff <= d_valid_ff;
         n_valid_ff <= p_valid_ff;
      end
      u_ff   <= u_in;
      v_ff   <= v_in;
      p_ff   <= p_in;
      n_ff.n_x <= n_in[0][NRM_BITS-1:0];
      n_ff.n_y <= n_in[1][NRM_BITS-1:0];
      n_ff.n_z <= n_in[2][NRM_BITS-1:0];
   end

   assign push      = n_valid_ff;
   assign push_data = n_ff;
endmodule

[sv/tun_fifo.sv]
`timescale 1ns / 1ps
module tun_fifo import tun_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  normal_type           push_data,
   input  logic                 pop,
   output logic                 not_empty,
   output normal_type           pop_data,
   output logic [QCNT_BITS-1:0] count
);
   normal_type           mem_ff [QUEUE_DEPTH];
   normal_type           pop_data_ff;
   logic [QPTR_BITS-1:0] wr_ff, rd_ff, rd_in;
   logic [QCNT_BITS-1:0] cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign do_push = push && (cnt_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign do_pop  = pop && (cnt_ff != '0);
   assign rd_in   = do_pop ? rd_ff + 1'b1 : rd_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         if (do_push) wr_ff <= wr_ff + 1'b1;
      end
      if (do_push) mem_ff[wr_ff] <= push_data;
      if (do_push && (wr_ff == rd_in)) begin
         pop_data_ff <= push_data;
      end else begin
         pop_data_ff <= mem_ff[rd_in];
      end
   end

   assign not_empty = (cnt_ff != '0);
   assign pop_data  = pop_data_ff;
   assign count     = cnt_ff;
endmodule

[sv/tun_back.sv]
`timescale 1ns / 1ps
module tun_back import tun_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  normal_type                 q_data,
   output logic                       q_pop,
   output logic                       rsp_valid,
   output logic signed [OUT_BITS-1:0] rsp_unit_x,
   output logic signed [OUT_BITS-1:0] rsp_unit_y,
   output logic signed [OUT_BITS-1:0] rsp_unit_z,
   output logic                       rsp_degenerate
);
   logic signed [NRM_BITS-1:0] nvec [3];
   logic [MAG_BITS-1:0]  mag1_in [3];
   logic [MAG_BITS-1:0]  mag1_ff [3];
   logic [MAG_BITS-1:0]  mag2_ff [3];
   logic [MAG_BITS-1:0]  mag3_ff [3];
   logic [MAG_BITS-1:0]  max2_in, max2_ff;
   logic [LZ_BITS-1:0]   lz3_in, lz3_ff;
   logic [2:0]           neg1_ff, neg2_ff, neg3_ff;
   logic                 deg3_ff;
   logic                 v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [MAG_BITS+NORM_BITS-1:0] wide [3];
   side_type             side4_in, side4_ff, side5_ff;
   logic [SQR_BITS-1:0]  sq5_ff [3];

   logic [SUM_BITS-1:0]    sq_s_ff [0:ROOT_BITS];
   logic [SQ_REM_BITS-1:0] sq_r_ff [0:ROOT_BITS];
   logic [ROOT_BITS-1:0]   sq_q_ff [0:ROOT_BITS];
   side_type               sq_d_ff [0:ROOT_BITS];
   logic                   sq_v_ff [0:ROOT_BITS];

   logic [DREM_BITS-1:0]  dv_r_ff [0:QUO_BITS][3];
   logic [QUO_BITS-1:0]   dv_l_ff [0:QUO_BITS][3];
   logic [QUO_BITS-1:0]   dv_q_ff [0:QUO_BITS][3];
   logic [ROOT_BITS-1:0]  dv_t_ff [0:QUO_BITS];
   side_type              dv_d_ff [0:QUO_BITS];
   logic                  dv_v_ff [0:QUO_BITS];
   logic [NORM_BITS-1:0]  mvec [3];
   logic [DIV_BITS-1:0]   dd_in [3];

   logic [QUO_BITS-1:0]        qs [3];
   logic signed [OUT_BITS-1:0] res_in [3];
   logic                       out_v_ff;
   logic signed [OUT_BITS-1:0] out_ff [3];
   logic                       out_deg_ff;

   assign q_pop = q_valid;

   always_comb begin
      nvec[0] = q_data.n_x;
      nvec[1] = q_data.n_y;
      nvec[2] = q_data.n_z;
      for (int i = 0; i < 3; i++) begin
         mag1_in[i] = nvec[i][NRM_BITS-1] ? MAG_BITS'(-nvec[i]) : MAG_BITS'(nvec[i]);
      end
      max2_in = (mag1_ff[0] >= mag1_ff[1]) ? mag1_ff[0] : mag1_ff[1];
      if (mag1_ff[2] > max2_in) max2_in = mag1_ff[2];
      lz3_in = LZ_BITS'(MAG_BITS);
      for (int k = 0; k < MAG_BITS; k++) begin
         if (max2_ff[k]) lz3_in = LZ_BITS'(MAG_BITS - 1 - k);
      end
      for (int i = 0; i < 3; i++) begin
         wide[i] = {mag3_ff[i], NORM_BITS'(0)} << lz3_ff;
      end
      side4_in.deg = deg3_ff;
      side4_in.neg = neg3_ff;
      side4_in.m_x = wide[0][MAG_BITS+NORM_BITS-1 -: NORM_BITS];
      side4_in.m_y = wide[1][MAG_BITS+NORM_BITS-1 -: NORM_BITS];
      side4_in.m_z = wide[2][MAG_BITS+NORM_BITS-1 -: NORM_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         sq_v_ff[0] <= 1'b0;
      end else begin
         v1_ff <= q_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         sq_v_ff[0] <= v5_ff;
      end
      mag1_ff  <= mag1_in;
      neg1_ff  <= {nvec[2][NRM_BITS-1], nvec[1][NRM_BITS-1], nvec[0][NRM_BITS-1]};
      mag2_ff  <= mag1_ff;
      neg2_ff  <= neg1_ff;
      max2_ff  <= max2_in;
      mag3_ff  <= mag2_ff;
      neg3_ff  <= neg2_ff;
      lz3_ff   <= lz3_in;
      deg3_ff  <= (max2_ff == '0);
      side4_ff <= side4_in;
      side5_ff <= side4_ff;
      sq5_ff[0] <= side4_ff.m_x * side4_ff.m_x;
      sq5_ff[1] <= side4_ff.m_y * side4_ff.m_y;
      sq5_ff[2] <= side4_ff.m_z * side4_ff.m_z;
      sq_s_ff[0] <= SUM_BITS'(sq5_ff[0]) + SUM_BITS'(sq5_ff[1]) + SUM_BITS'(sq5_ff[2]);
      sq_r_ff[0] <= '0;
      sq_q_ff[0] <= '0;
      sq_d_ff[0] <= side5_ff;
   end

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
      logic [SQ_REM_BITS-1:0] rt, trial;
      logic                   ge;
      always_comb begin
         rt    = {sq_r_ff[k][SQ_REM_BITS-3:0], sq_s_ff[k][SUM_BITS-1 -: 2]};
         trial = {1'b0, sq_q_ff[k], 2'b01};
         ge    = (rt >= trial);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
         sq_r_ff[k+1] <= ge ? rt - trial : rt;
         sq_s_ff[k+1] <= {sq_s_ff[k][SUM_BITS-3:0], 2'b00};
         sq_q_ff[k+1] <= {sq_q_ff[k][ROOT_BITS-2:0], ge};
         sq_d_ff[k+1] <= sq_d_ff[k];
      end
   end

   always_comb begin
      mvec[0] = sq_d_ff[ROOT_BITS].m_x;
      mvec[1] = sq_d_ff[ROOT_BITS].m_y;
      mvec[2] = sq_d_ff[ROOT_BITS].m_z;
      for (int i = 0; i < 3; i++) begin
         dd_in[i] = DIV_BITS'({mvec[i], FRACTION_BITS'(0)})
                  + DIV_BITS'(sq_q_ff[ROOT_BITS] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else begin
         dv_v_ff[0] <= sq_v_ff[ROOT_BITS];
      end
      for (int i = 0; i < 3; i++) begin
         dv_r_ff[0][i] <= DREM_BITS'(dd_in[i] >> QUO_BITS);
         dv_l_ff[0][i] <= dd_in[i][QUO_BITS-1:0];
         dv_q_ff[0][i] <= '0;
      end
      dv_t_ff[0] <= sq_q_ff[ROOT_BITS];
      dv_d_ff[0] <= sq_d_ff[ROOT_BITS];
   end

   for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
      for (genvar i = 0; i < 3; i++) begin : g_lane
         logic [DREM_BITS-1:0] rt, dv;
         logic                 ge;
         always_comb begin
            rt = {dv_r_ff[j][i][DREM_BITS-2:0], dv_l_ff[j][i][QUO_BITS-1]};
            dv = {1'b0, dv_t_ff[j]};
            ge = (rt >= dv);
         end
         always_ff @(posedge clock) begin
            dv_r_ff[j+1][i] <= ge ? rt - dv : rt;
            dv_l_ff[j+1][i] <= {dv_l_ff[j][i][QUO_BITS-2:0], 1'b0};
            dv_q_ff[j+1][i] <= {dv_q_ff[j][i][QUO_BITS-2:0], ge};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j+1] <= 1'b0;
         end else begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
         dv_t_ff[j+1] <= dv_t_ff[j];
         dv_d_ff[j+1] <= dv_d_ff[j];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qs[i] = (dv_q_ff[QUO_BITS][i] > LIMIT) ? LIMIT : dv_q_ff[QUO_BITS][i];
         if (dv_d_ff[QUO_BITS].deg) begin
            res_in[i] = '0;
         end else if (dv_d_ff[QUO_BITS].neg[i]) begin
            res_in[i] = -OUT_BITS'(qs[i]);
         end else begin
            res_in[i] = OUT_BITS'(qs[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= dv_v_ff[QUO_BITS];
      end
      out_ff     <= res_in;
      out_deg_ff <= dv_d_ff[QUO_BITS].deg;
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_unit_x     = out_ff[0];
   assign rsp_unit_y     = out_ff[1];
   assign rsp_unit_z     = out_ff[2];
   assign rsp_degenerate = out_deg_ff;
endmodule

[sv/triangle_unit_normal.sv]
`timescale 1ns / 1ps
// One triangle word is taken per clock whenever start is high and busy is low, and its
// unit normal leaves on the rsp_ ports, marked by rsp_valid for one cycle, in the order of
// acceptance. Its path runs through the 31-stage square root pipeline and the 16-stage
// divider pipeline behind it. The result side drains every cycle, so busy is high only
// during reset.
module triangle_unit_normal import tun_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_a_x,
   input  logic signed [COORD_BITS-1:0] req_a_y,
   input  logic signed [COORD_BITS-1:0] req_a_z,
   input  logic signed [COORD_BITS-1:0] req_b_x,
   input  logic signed [COORD_BITS-1:0] req_b_y,
   input  logic signed [COORD_BITS-1:0] req_b_z,
   input  logic signed [COORD_BITS-1:0] req_c_x,
   input  logic signed [COORD_BITS-1:0] req_c_y,
   input  logic signed [COORD_BITS-1:0] req_c_z,
   output logic                         rsp_valid,
   output logic signed [OUT_BITS-1:0]   rsp_unit_x,
   output logic signed [OUT_BITS-1:0]   rsp_unit_y,
   output logic signed [OUT_BITS-1:0]   rsp_unit_z,
   output logic                         rsp_degenerate
);
   logic                 accept, push, pop, not_empty;
   normal_type           push_data, pop_data;
   logic [QCNT_BITS-1:0] count;

   assign busy   = reset || (count > QUEUE_ROOM);
   assign accept = start && !busy;

   tun_front u_front (
      .clock(clock), .reset(reset), .accept(accept),
      .a_x(req_a_x), .a_y(req_a_y), .a_z(req_a_z),
      .b_x(req_b_x), .b_y(req_b_y), .b_z(req_b_z),
      .c_x(req_c_x), .c_y(req_c_y), .c_z(req_c_z),
      .push(push), .push_data(push_data)
   );

   tun_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .pop(pop), .not_empty(not_empty), .pop_data(pop_data), .count(count)
   );

   tun_back u_back (
      .clock(clock), .reset(reset), .q_valid(not_empty), .q_data(pop_data),
      .q_pop(pop), .rsp_valid(rsp_valid), .rsp_unit_x(rsp_unit_x),
      .rsp_unit_y(rsp_unit_y), .rsp_unit_z(rsp_unit_z),
      .rsp_degenerate(rsp_degenerate)
   );
endmodule

[sv/tun_checker.sv]
`timescale 1ns / 1ps
module tun_checker import tun_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic signed [OUT_BITS-1:0] rsp_unit_x,
   input logic signed [OUT_BITS-1:0] rsp_unit_y,
   input logic signed [OUT_BITS-1:0] rsp_unit_z,
   input logic                       rsp_degenerate
);
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised outside reset");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_unit_x == '0 && rsp_unit_y == '0 && rsp_unit_z == '0)
      else $error("degenerate word carries a nonzero normal");

   a_not_all_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_unit_x != '0 || rsp_unit_y != '0 || rsp_unit_z != '0)
      else $error("normal of a proper triangle is zero");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_unit_x != 16'sh8000 && rsp_unit_y != 16'sh8000
         && rsp_unit_z != 16'sh8000)
      else $error("normal component outside the saturated range");
endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_unit_x(rsp_unit_x), .rsp_unit_y(rsp_unit_y),
   .rsp_unit_z(rsp_unit_z), .rsp_degenerate(rsp_degenerate)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top import tun_pkg::*; ();

   typedef struct {
      logic signed [15:0] ux;
      logic signed [15:0] uy;
      logic signed [15:0] uz;
      logic               deg;
   } normal_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [COORD_BITS-1:0] a_x = '0, a_y = '0, a_z = '0;
   logic signed [COORD_BITS-1:0] b_x = '0, b_y = '0, b_z = '0;
   logic signed [COORD_BITS-1:0] c_x = '0, c_y = '0, c_z = '0;
   logic rsp_valid;
   logic signed [OUT_BITS-1:0] rsp_unit_x, rsp_unit_y, rsp_unit_z;
   logic rsp_degenerate;

   normal_word_type expected_normals[$];
   int errors = 0;
   int idle_pct = 0;

   always #4 clock = ~clock;

   triangle_unit_normal u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_x(a_x), .req_a_y(a_y), .req_a_z(a_z),
      .req_b_x(b_x), .req_b_y(b_y), .req_b_z(b_z),
      .req_c_x(c_x), .req_c_y(c_y), .req_c_z(c_z),
      .rsp_valid(rsp_valid), .rsp_unit_x(rsp_unit_x), .rsp_unit_y(rsp_unit_y),
      .rsp_unit_z(rsp_unit_z), .rsp_degenerate(rsp_degenerate)
   );

   function automatic logic [63:0] int_sqrt(logic [63:0] s);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s = s - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic normal_word_type face_normal(logic signed [15:0] v[9]);
      normal_word_type r;
      longint n[3];
      logic [63:0] m[3];
      logic [63:0] maxm, s, t, q;
      longint ux, uy, uz, vx, vy, vz;
      int len;
      ux = v[3] - v[0]; uy = v[4] - v[1]; uz = v[5] - v[2];
      vx = v[6] - v[0]; vy = v[7] - v[1]; vz = v[8] - v[2];
      n[0] = uy * vz - uz * vy;
      n[1] = uz * vx - ux * vz;
      n[2] = ux * vy - uy * vx;
      for (int i = 0; i < 3; i++) m[i] = n[i] < 0 ? -n[i] : n[i];
      maxm = m[0];
      if (m[1] > maxm) maxm = m[1];
      if (m[2] > maxm) maxm = m[2];
      r = '{0, 0, 0, 1'b1};
      if (maxm == 0) return r;
      len = 0;
      while (len < 64 && (maxm >> len) != 0) len++;
      for (int i = 0; i < 3; i++) begin
         if (len > 30) m[i] = m[i] >> (len - 30);
         else m[i] = m[i] << (30 - len);
      end
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      t = int_sqrt(s);
      if (t == 0) t = 1;
      r.deg = 1'b0;
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << FRACTION_BITS) + (t >> 1)) / t;
         if (q > LIMIT_INT) q = LIMIT_INT;
         if (n[i] < 0) q = -q;
         if (i == 0) r.ux = q[15:0];
         else if (i == 1) r.uy = q[15:0];
         else r.uz = q[15:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("Mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
   endtask

   task automatic send_triangle(logic signed [15:0] v[9]);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      a_x <= v[0]; a_y <= v[1]; a_z <= v[2];
      b_x <= v[3]; b_y <= v[4]; b_z <= v[5];
      c_x <= v[6]; c_y <= v[7]; c_z <= v[8];
      start <= 1'b1;
      do @(posedge clock); while (busy);
      expected_normals.push_back(face_normal(v));
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      normal_word_type e;
      if (!reset && rsp_valid) begin
         if (expected_normals.size() == 0) begin
            report_mismatch("unexpected word", 0, 0);
         end else begin
            e = expected_normals.pop_front();
            if (rsp_unit_x !== e.ux) report_mismatch("unit_x", rsp_unit_x, e.ux);
            if (rsp_unit_y !== e.uy) report_mismatch("unit_y", rsp_unit_y, e.uy);
            if (rsp_unit_z !== e.uz) report_mismatch("unit_z", rsp_unit_z, e.uz);
            if (rsp_degenerate !== e.deg)
               report_mismatch("degenerate", rsp_degenerate, e.deg);
         end
      end
   end

   function automatic logic signed [15:0] pick_coord();
      case ($urandom_range(5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'(int'($urandom_range(16)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      logic signed [15:0] v[9];
      v = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_triangle(v);
      v = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; send_triangle(v);
      v = '{0, 0, 0, 0, 1, 0, 1, 0, 0}; send_triangle(v);
      v = '{0, 0, 0, 0, 0, 1, 1, 0, 0}; send_triangle(v);
      v = '{1, 2, 3, 2, 4, 6, 3, 6, 9}; send_triangle(v);
      v = '{5, 5, 5, 5, 5, 5, 9, 1, 3}; send_triangle(v);
      v = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
      send_triangle(v);
      v = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
      send_triangle(v);
      v = '{-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767, 32767};
      send_triangle(v);
      v = '{32767, -32768, 0, -32768, 32767, 0, 0, 0, -32768}; send_triangle(v);
      v = '{0, 0, 0, 1, 1, 1, -1, 1, 0}; send_triangle(v);
      v = '{0, 0, 0, -1, -1, -1, 1, -1, 0}; send_triangle(v);
      v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; send_triangle(v);
   endtask

   task automatic test_random(int count);
      logic signed [15:0] v[9];
      for (int k = 0; k < count; k++) begin
         for (int i = 0; i < 9; i++) v[i] = pick_coord();
         if ($urandom_range(9) == 0) begin
            v[6] = v[3]; v[7] = v[4]; v[8] = v[5];
         end
         send_triangle(v);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_pct = 8;
      test_directed();
      test_random(400);
      idle_pct = 67;
      test_random(400);
      idle_pct = 0;
      test_random(400);
      start <= 1'b0;
      while (expected_normals.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
      if (errors == 0 && expected_normals.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
